FILE: rtl/bcd_as_pkg.sv
// ----------------------------------------------------------------------------
// BCD add/subtract package
// Shared widths, opcode codes, operand/result records and a digit clamp
// function for the signed packed-BCD adder/subtractor.
// ----------------------------------------------------------------------------
package bcd_as_pkg;

  localparam int DIGITS_DEF = 16;
  localparam int DIGITS_MAX = 16;
  localparam int DATA_W     = 4 * DIGITS_MAX;

  typedef enum logic {
    OPC_ADD = 1'b0,
    OPC_SUB = 1'b1
  } opc_t;

  typedef struct packed {
    opc_t              opcode;
    logic              a_negative;
    logic [DATA_W-1:0] a_digits;
    logic              b_negative;
    logic [DATA_W-1:0] b_digits;
  } operands_t;

  typedef struct packed {
    logic              result_negative;
    logic [DATA_W-1:0] result_digits;
    logic              saturated;
  } result_t;

  // read any non-decimal nibble as nine
  function automatic logic [DATA_W-1:0] clamp_digits(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v;
    for (int i = 0; i < DIGITS_MAX; i++) begin
      if (v[4*i +: 4] > 4'd9) begin
        r[4*i +: 4] = 4'd9;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/bcd_as_in_if.sv
// ----------------------------------------------------------------------------
// Operand channel
// Valid/ready channel carrying the opcode and the two signed BCD operands.
// ----------------------------------------------------------------------------
interface bcd_as_in_if;

  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic                          a_negative;
  logic [bcd_as_pkg::DATA_W-1:0] a_digits;
  logic                          b_negative;
  logic [bcd_as_pkg::DATA_W-1:0] b_digits;

  modport source (
    output valid, opcode, a_negative, a_digits, b_negative, b_digits,
    input  ready
  );

  modport sink (
    input  valid, opcode, a_negative, a_digits, b_negative, b_digits,
    output ready
  );

endinterface

FILE: rtl/bcd_as_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the signed BCD result and saturation flag.
// ----------------------------------------------------------------------------
interface bcd_as_out_if;

  logic                          valid;
  logic                          ready;
  logic                          result_negative;
  logic [bcd_as_pkg::DATA_W-1:0] result_digits;
  logic                          saturated;

  modport source (
    output valid, result_negative, result_digits, saturated,
    input  ready
  );

  modport sink (
    input  valid, result_negative, result_digits, saturated,
    output ready
  );

endinterface

FILE: rtl/bcd_as_core.sv
// ----------------------------------------------------------------------------
// BCD add/subtract datapath
// Decimal sum by excess-six binary add, decimal differences by binary
// subtract with per-digit borrow correction, magnitude compare and sign.
// ----------------------------------------------------------------------------
module bcd_as_core #(
  parameter int DIGITS = bcd_as_pkg::DIGITS_DEF
) (
  input  bcd_as_pkg::operands_t op,
  output bcd_as_pkg::result_t   res
);

  localparam int W = 4 * DIGITS;

  logic [bcd_as_pkg::DATA_W-1:0] a_cl;
  logic [bcd_as_pkg::DATA_W-1:0] b_cl;
  logic [W-1:0]                  a_m;
  logic [W-1:0]                  b_m;
  logic [W-1:0]                  a_ex6;
  logic [W:0]                    sum_bin;
  logic [W:0]                    sum_cy;
  logic [W:0]                    dab_bin;
  logic [W:0]                    dab_bw;
  logic [W:0]                    dba_bin;
  logic [W:0]                    dba_bw;
  logic [W-1:0]                  sum_dec;
  logic [W-1:0]                  dab_dec;
  logic [W-1:0]                  dba_dec;
  logic [W-1:0]                  mag;
  logic                          eff_sub;
  logic                          a_ge_b;
  logic                          ovf;

  assign a_cl = bcd_as_pkg::clamp_digits(op.a_digits);
  assign b_cl = bcd_as_pkg::clamp_digits(op.b_digits);
  assign a_m  = a_cl[W-1:0];
  assign b_m  = b_cl[W-1:0];

  assign a_ex6   = a_m + {DIGITS{4'h6}};
  assign sum_bin = {1'b0, a_ex6} + {1'b0, b_m};
  assign sum_cy  = {1'b0, a_ex6} ^ {1'b0, b_m} ^ sum_bin;

  assign dab_bin = {1'b0, a_m} - {1'b0, b_m};
  assign dab_bw  = {1'b0, a_m} ^ {1'b0, b_m} ^ dab_bin;
  assign dba_bin = {1'b0, b_m} - {1'b0, a_m};
  assign dba_bw  = {1'b0, b_m} ^ {1'b0, a_m} ^ dba_bin;

  for (genvar i = 0; i < DIGITS; i++) begin : g_dig
    assign sum_dec[4*i +: 4] = sum_cy[4*i+4] ? sum_bin[4*i +: 4]
                                             : sum_bin[4*i +: 4] - 4'd6;
    assign dab_dec[4*i +: 4] = dab_bw[4*i+4] ? dab_bin[4*i +: 4] - 4'd6
                                             : dab_bin[4*i +: 4];
    assign dba_dec[4*i +: 4] = dba_bw[4*i+4] ? dba_bin[4*i +: 4] - 4'd6
                                             : dba_bin[4*i +: 4];
  end

  assign ovf     = sum_bin[W];
  assign a_ge_b  = ~dab_bin[W];
  assign eff_sub = (op.opcode == bcd_as_pkg::OPC_SUB) ^ op.a_negative ^ op.b_negative;

  always_comb begin
    if (!eff_sub) begin
      mag = ovf ? {DIGITS{4'h9}} : sum_dec;
    end else if (a_ge_b) begin
      mag = dab_dec;
    end else begin
      mag = dba_dec;
    end
  end

  assign res.result_negative = op.a_negative ^ (eff_sub & ~a_ge_b);
  assign res.result_digits   = bcd_as_pkg::DATA_W'(mag);
  assign res.saturated       = ~eff_sub & ovf;

endmodule

FILE: rtl/bcd_sign_magnitude_add_sub.sv
// ----------------------------------------------------------------------------
// Signed packed-BCD adder/subtractor
// Path: an operand transfer is held in the input register, then in the
//   result register, which drives result valid.
// Throughput: one operand pair per cycle while the output is not
//   back-pressured. Both stages hold under output back-pressure.
// Reset: synchronous active-low rst_n clears both stage valid flags.
// ----------------------------------------------------------------------------
module bcd_sign_magnitude_add_sub #(
  parameter int DIGITS = bcd_as_pkg::DIGITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bcd_as_in_if.sink    in_chan,
  bcd_as_out_if.source out_chan
);

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  bcd_as_pkg::operands_t s1_op_r;
  logic                  s2_valid_r;
  logic                  s2_valid_nxt;
  bcd_as_pkg::result_t   s2_res_r;
  bcd_as_pkg::result_t   core_res;
  bcd_as_pkg::operands_t in_op;
  logic                  s2_free;
  logic                  in_xfer;

  assign in_op.opcode     = bcd_as_pkg::opc_t'(in_chan.opcode);
  assign in_op.a_negative = in_chan.a_negative;
  assign in_op.a_digits   = in_chan.a_digits;
  assign in_op.b_negative = in_chan.b_negative;
  assign in_op.b_digits   = in_chan.b_digits;

  assign s2_free       = ~s2_valid_r | out_chan.ready;
  assign in_chan.ready = ~s1_valid_r | s2_free;
  assign in_xfer       = in_chan.valid & in_chan.ready;

  bcd_as_core #(
    .DIGITS (DIGITS)
  ) u_core (
    .op  (s1_op_r),
    .res (core_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_free) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_free ? s1_valid_r : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // hold payloads unless the stage advances
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r <= in_op;
    end
    if (s2_free && s1_valid_r) begin
      s2_res_r <= core_res;
    end
  end

  assign out_chan.valid           = s2_valid_r;
  assign out_chan.result_negative = s2_res_r.result_negative;
  assign out_chan.result_digits   = s2_res_r.result_digits;
  assign out_chan.saturated       = s2_res_r.saturated;

  a_in_loads_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("operand transfer not captured in input stage");

  a_s1_moves_to_s2 : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_free) |=> s2_valid_r)
    else $error("input stage advanced without filling result stage");

  a_sat_is_nines : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.saturated) |->
      (out_chan.result_digits == bcd_as_pkg::DATA_W'({DIGITS{4'h9}})))
    else $error("saturated result is not all nines");

  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_chan.valid && in_chan.ready))
    else $error("pipeline not empty after reset");

endmodule
